// ===== sv/gcb_pkg.sv =====
`timescale 1ns / 1ps
package gcb_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int STG_W         = 5;
    localparam int ANG_W         = 36;
    localparam int RV_W          = 36;
    localparam int TRIG_W        = 32;
    localparam int FRAC          = 30;
    localparam int SQRT_STEPS    = 32;
    localparam int SQ_W          = 2 * SQRT_STEPS - 1;
    localparam int NROT          = 5;
    localparam int NVEC          = 2;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;

    // register stages from request to result
    localparam int LAT     = 43 + 2 * CORDIC_STAGES;
    localparam int DEG_DLY = SQRT_STEPS - 3;

    localparam logic signed [ANG_W-1:0] PI_Q         = ANG_W'(64'sd3373259426);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q    = ANG_W'(64'sd1686629713);
    localparam logic signed [ANG_W-1:0] TWO_PI_Q     = ANG_W'(64'sd6746518852);
    localparam logic signed [ANG_W-1:0] QUARTER_PI_Q = ANG_W'(64'sd843314857);
    localparam logic signed [RV_W-1:0]  GAIN_Q       = RV_W'(64'sd652032874);
    localparam logic [FRAC:0]           ONE_Q        = (FRAC+1)'(1) << FRAC;

    localparam int DEG_HALF  = 180;
    localparam int DEG_FULL  = 360;
    localparam int DEG_SHIFT = 40;
    localparam logic [15:0] DEG_RECIP = 16'((64'd180 << DEG_SHIFT) / 64'd3373259426);

    localparam logic [23:0] RADIUS_RESET = 24'd6371000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TLAT   = 2'd0,
        CFG_TLON   = 2'd1,
        CFG_RADIUS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [RV_W-1:0]  x;
        logic signed [RV_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
    } t_rot;

    typedef struct packed {
        logic signed [RV_W-1:0]  x;
        logic signed [RV_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } t_vec;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sq;

    // atan(2^-i) in Q30 from the power series in Q62, rounded to nearest
    function automatic logic signed [ANG_W-1:0] f_atan_q(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        int unsigned d;
        int unsigned sh;
        int          k;
        int          b;
        sum = '0;
        if (i == 0) begin
            return QUARTER_PI_Q;
        end
        for (k = 0; k < 32; k++) begin
            d  = 2 * k + 1;
            sh = i * d;
            if (sh <= 62) begin
                num = 64'd1 << (62 - sh);
                quo = '0;
                rem = '0;
                for (b = 63; b >= 0; b--) begin
                    rem = {rem[62:0], num[b]};
                    if (rem >= 64'(d)) begin
                        rem    = rem - 64'(d);
                        quo[b] = 1'b1;
                    end
                end
                sum = k[0] ? sum - quo : sum + quo;
            end
        end
        sum = (sum + (64'd1 << 31)) >> 32;
        return ANG_W'(sum);
    endfunction

    // wrap into [-pi, pi], fold into [-pi/2, pi/2]
    function automatic t_rot f_rot_prep(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] z;
        t_rot                    r;
        z      = a;
        r.flip = 1'b0;
        if (z > PI_Q) begin
            z = z - TWO_PI_Q;
        end else if (z < -PI_Q) begin
            z = z + TWO_PI_Q;
        end
        if (z > HALF_PI_Q) begin
            z      = z - PI_Q;
            r.flip = 1'b1;
        end else if (z < -HALF_PI_Q) begin
            z      = z + PI_Q;
            r.flip = 1'b1;
        end
        r.x = GAIN_Q;
        r.y = '0;
        r.z = z;
        return r;
    endfunction

    // move left half-plane vectors to the right, start angle at +-pi
    function automatic t_vec f_vec_prep(input logic signed [RV_W-1:0] y,
                                        input logic signed [RV_W-1:0] x);
        t_vec r;
        r.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            r.z = (y >= 0) ? PI_Q : -PI_Q;
            r.x = -x;
            r.y = -y;
        end else begin
            r.z = '0;
            r.x = x;
            r.y = y;
        end
        return r;
    endfunction

    function automatic logic signed [TRIG_W-1:0] f_qmul(input logic signed [TRIG_W-1:0] a,
                                                        input logic signed [TRIG_W-1:0] b);
        logic signed [2*TRIG_W-1:0] p;
        p = a * b + ((2*TRIG_W)'(1) <<< (FRAC - 1));
        p = p >>> FRAC;
        return p[TRIG_W-1:0];
    endfunction

endpackage

// ===== sv/great_circle_bearing_distance_unit.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// request   start / busy         i_current_latitude, i_current_longitude
// result    o_done (strobe)      o_bearing_deg, o_distance_m
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request per cycle; busy is always low since every stage advances each cycle.
// The rotation chain (24 stages), the square-root chain (32 cells) and the vectoring chain
// lie in series.
// i_rst_n is synchronous, active low: it drops requests in flight and restores
// the waypoint to zero and the radius to 6371000 m.
// The receiver cannot stall; each result shows for exactly one cycle.
module great_circle_bearing_distance_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [30:0]                    i_current_latitude,
    input  logic signed [31:0]                    i_current_longitude,
    input  logic                                  i_cfg_we,
    input  logic [gcb_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [gcb_pkg::CFG_W-1:0]             i_cfg_data,
    output logic                                  o_done,
    output logic [8:0]                            o_bearing_deg,
    output logic [25:0]                           o_distance_m
);
    import gcb_pkg::*;

    // configuration: active waypoint and sphere radius
    logic signed [30:0] r_tlat;
    logic signed [31:0] r_tlon;
    logic [23:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlat   <= '0;
            r_tlon   <= '0;
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TLAT:   r_tlat   <= i_cfg_data[30:0];
                CFG_TLON:   r_tlon   <= i_cfg_data[31:0];
                CFG_RADIUS: r_radius <= i_cfg_data[23:0];
                default:    ;
            endcase
        end
    end

    // request valid travels alongside the data
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[LAT-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // capture the request
    logic signed [30:0] r_clat;
    logic signed [31:0] r_clon;

    always_ff @(posedge i_clk) begin
        r_clat <= i_current_latitude;
        r_clon <= i_current_longitude;
    end

    // five rotation angles: full clat, full tlat, full dlon, half dlat, half dlon
    logic signed [ANG_W-1:0] w_dlon;
    logic signed [ANG_W-1:0] w_ang [NROT];
    t_rot                    r_rot [NROT];
    t_rot                    w_rot [NROT][CORDIC_STAGES+1];

    always_comb begin
        w_dlon   = ANG_W'(r_tlon) - ANG_W'(r_clon);
        w_ang[0] = ANG_W'(r_clat) <<< 1;
        w_ang[1] = ANG_W'(r_tlat) <<< 1;
        w_ang[2] = w_dlon <<< 1;
        w_ang[3] = ANG_W'(r_tlat) - ANG_W'(r_clat);
        w_ang[4] = w_dlon;
    end

    for (genvar g_u = 0; g_u < NROT; g_u++) begin : g_rot
        always_ff @(posedge i_clk) begin
            r_rot[g_u] <= f_rot_prep(w_ang[g_u]);
        end
        assign w_rot[g_u][0] = r_rot[g_u];
        for (genvar g_k = 0; g_k < CORDIC_STAGES; g_k++) begin : g_stg
            localparam logic signed [ANG_W-1:0] ANG = f_atan_q(g_k);
            gcb_rot_cell u_cell (
                .i_clk   (i_clk),
                .i_stage (STG_W'(g_k)),
                .i_angle (ANG),
                .i_d     (w_rot[g_u][g_k]),
                .o_q     (w_rot[g_u][g_k+1])
            );
        end
    end

    // undo the fold by pi
    logic signed [TRIG_W-1:0] r_sin [NROT];
    logic signed [TRIG_W-1:0] r_cos [NROT];

    for (genvar g_u = 0; g_u < NROT; g_u++) begin : g_flip
        always_ff @(posedge i_clk) begin
            r_sin[g_u] <= TRIG_W'(w_rot[g_u][CORDIC_STAGES].flip ?
                          -w_rot[g_u][CORDIC_STAGES].y : w_rot[g_u][CORDIC_STAGES].y);
            r_cos[g_u] <= TRIG_W'(w_rot[g_u][CORDIC_STAGES].flip ?
                          -w_rot[g_u][CORDIC_STAGES].x : w_rot[g_u][CORDIC_STAGES].x);
        end
    end

    // products, one multiply per register
    logic signed [TRIG_W-1:0] r_y2, r_p1_2, r_p2_2, r_h1_2, r_h2_2, r_cdl2, r_cc2, r_ct2;
    logic signed [TRIG_W-1:0] r_y3, r_p1_3, r_p3_3, r_h1_3, r_h3_3, r_ct3;
    logic signed [TRIG_W:0]   r_x4;
    logic signed [TRIG_W-1:0] r_y4, r_h1_4, r_h4_4;
    logic signed [TRIG_W:0]   r_x5;
    logic signed [TRIG_W-1:0] r_y5;
    logic [FRAC:0]            r_a5;
    logic signed [TRIG_W:0]   w_asum;

    always_ff @(posedge i_clk) begin
        r_y2   <= f_qmul(r_sin[2], r_cos[1]);
        r_p1_2 <= f_qmul(r_cos[0], r_sin[1]);
        r_p2_2 <= f_qmul(r_sin[0], r_cos[1]);
        r_h1_2 <= f_qmul(r_sin[3], r_sin[3]);
        r_h2_2 <= f_qmul(r_sin[4], r_sin[4]);
        r_cdl2 <= r_cos[2];
        r_cc2  <= r_cos[0];
        r_ct2  <= r_cos[1];

        r_y3   <= r_y2;
        r_p1_3 <= r_p1_2;
        r_p3_3 <= f_qmul(r_p2_2, r_cdl2);
        r_h1_3 <= r_h1_2;
        r_h3_3 <= f_qmul(r_h2_2, r_cc2);
        r_ct3  <= r_ct2;

        r_x4   <= (TRIG_W+1)'(r_p1_3) - (TRIG_W+1)'(r_p3_3);
        r_y4   <= r_y3;
        r_h1_4 <= r_h1_3;
        r_h4_4 <= f_qmul(r_h3_3, r_ct3);

        r_x5   <= r_x4;
        r_y5   <= r_y4;
        // clamp the haversine term to [0, 1]
        if (w_asum < 0) begin
            r_a5 <= '0;
        end else if (w_asum > (TRIG_W+1)'(ONE_Q)) begin
            r_a5 <= ONE_Q;
        end else begin
            r_a5 <= w_asum[FRAC:0];
        end
    end

    assign w_asum = (TRIG_W+1)'(r_h1_4) + (TRIG_W+1)'(r_h4_4);

    // two square-root chains: sqrt(a) and sqrt(1 - a), both in Q30
    t_sq r_sq [NVEC];
    t_sq w_sq [NVEC][SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        r_sq[0].v <= SQ_W'(r_a5) << FRAC;
        r_sq[0].r <= '0;
        r_sq[1].v <= SQ_W'(ONE_Q - r_a5) << FRAC;
        r_sq[1].r <= '0;
    end

    for (genvar g_u = 0; g_u < NVEC; g_u++) begin : g_sqrt
        assign w_sq[g_u][0] = r_sq[g_u];
        for (genvar g_k = 0; g_k < SQRT_STEPS; g_k++) begin : g_stg
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - g_k));
            gcb_sqrt_cell u_cell (
                .i_clk (i_clk),
                .i_bit (BIT),
                .i_d   (w_sq[g_u][g_k]),
                .o_q   (w_sq[g_u][g_k+1])
            );
        end
    end

    // vectoring chains: bearing angle from (x, y), half the central angle from the roots
    t_vec r_vec [NVEC];
    t_vec w_vec [NVEC][CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        r_vec[0] <= f_vec_prep(RV_W'(r_y5), RV_W'(r_x5));
        r_vec[1] <= f_vec_prep(RV_W'(w_sq[0][SQRT_STEPS].r), RV_W'(w_sq[1][SQRT_STEPS].r));
    end

    for (genvar g_u = 0; g_u < NVEC; g_u++) begin : g_vec
        assign w_vec[g_u][0] = r_vec[g_u];
        for (genvar g_k = 0; g_k < CORDIC_STAGES; g_k++) begin : g_stg
            localparam logic signed [ANG_W-1:0] ANG = f_atan_q(g_k);
            gcb_vec_cell u_cell (
                .i_clk   (i_clk),
                .i_stage (STG_W'(g_k)),
                .i_angle (ANG),
                .i_d     (w_vec[g_u][g_k]),
                .o_q     (w_vec[g_u][g_k+1])
            );
        end
    end

    // bearing to degrees: floor((b + 2pi) * 180 / pi) mod 360, via reciprocal
    localparam int DEG_N_W = 42;
    localparam int DEG_P_W = 50;
    localparam int DEG_Q_W = 10;

    t_vec                    w_bvec;
    logic signed [ANG_W-1:0] w_bsum;
    logic [33:0]             w_bw;
    logic [DEG_N_W-1:0]      r_n1, r_n2, r_n3, w_rem;
    logic [DEG_P_W-1:0]      r_pr1;
    logic [DEG_Q_W-1:0]      r_qe2, r_qe3, r_q4;
    logic [DEG_N_W-1:0]      r_m3;
    logic [8:0]              r_deg5;

    assign w_bvec = w_vec[0][CORDIC_STAGES];
    assign w_bsum = (w_bvec.zero ? '0 : w_bvec.z) + TWO_PI_Q;
    assign w_bw   = w_bsum[33:0];
    assign w_rem  = r_n3 - r_m3;

    always_ff @(posedge i_clk) begin
        r_n1   <= DEG_N_W'(w_bw) * DEG_N_W'(DEG_HALF);
        r_pr1  <= DEG_P_W'(w_bw) * DEG_P_W'(DEG_RECIP);
        r_n2   <= r_n1;
        r_qe2  <= DEG_Q_W'(r_pr1 >> DEG_SHIFT);
        r_n3   <= r_n2;
        r_qe3  <= r_qe2;
        r_m3   <= DEG_N_W'(r_qe2) * DEG_N_W'(PI_Q);
        // estimate is low by at most one
        r_q4   <= (w_rem >= DEG_N_W'(PI_Q)) ? r_qe3 + 1'b1 : r_qe3;
        r_deg5 <= (r_q4 >= DEG_Q_W'(DEG_FULL)) ? 9'(r_q4 - DEG_Q_W'(DEG_FULL)) : 9'(r_q4);
    end

    // hold the bearing until the distance catches up
    logic [8:0] r_deg_dly [DEG_DLY];

    always_ff @(posedge i_clk) begin
        r_deg_dly[0] <= r_deg5;
        for (int i = 1; i < DEG_DLY; i++) begin
            r_deg_dly[i] <= r_deg_dly[i-1];
        end
    end

    // distance = radius * 2 * angle, angle in Q30
    t_vec                    w_dvec;
    logic signed [ANG_W-1:0] w_dz;
    logic [30:0]             w_dang;
    logic [54:0]             r_prod;
    logic [8:0]              r_bearing;
    logic [25:0]             r_dist;

    assign w_dvec = w_vec[1][CORDIC_STAGES];
    assign w_dz   = w_dvec.zero ? '0 : w_dvec.z;
    assign w_dang = (w_dz < 0) ? '0 : w_dz[30:0];

    always_ff @(posedge i_clk) begin
        r_prod    <= 55'(r_radius) * 55'(w_dang);
        r_bearing <= r_deg_dly[DEG_DLY-1];
        r_dist    <= r_prod[FRAC-1+25:FRAC-1];
    end

    assign o_done        = r_vld[LAT-1];
    assign o_bearing_deg = r_bearing;
    assign o_distance_m  = r_dist;
endmodule

// ===== sv/gcb_rot_cell.sv =====
`timescale 1ns / 1ps
module gcb_rot_cell (
    input  logic                             i_clk,
    input  logic [gcb_pkg::STG_W-1:0]        i_stage,
    input  logic signed [gcb_pkg::ANG_W-1:0] i_angle,
    input  gcb_pkg::t_rot                    i_d,
    output gcb_pkg::t_rot                    o_q
);
    import gcb_pkg::*;

    t_rot r_q;
    t_rot n_q;

    // rotate toward zero residual angle
    always_comb begin
        n_q.flip = i_d.flip;
        if (!i_d.z[ANG_W-1]) begin
            n_q.x = i_d.x - (i_d.y >>> i_stage);
            n_q.y = i_d.y + (i_d.x >>> i_stage);
            n_q.z = i_d.z - i_angle;
        end else begin
            n_q.x = i_d.x + (i_d.y >>> i_stage);
            n_q.y = i_d.y - (i_d.x >>> i_stage);
            n_q.z = i_d.z + i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

// ===== sv/gcb_vec_cell.sv =====
`timescale 1ns / 1ps
module gcb_vec_cell (
    input  logic                             i_clk,
    input  logic [gcb_pkg::STG_W-1:0]        i_stage,
    input  logic signed [gcb_pkg::ANG_W-1:0] i_angle,
    input  gcb_pkg::t_vec                    i_d,
    output gcb_pkg::t_vec                    o_q
);
    import gcb_pkg::*;

    t_vec r_q;
    t_vec n_q;

    // drive y toward zero, accumulate the angle
    always_comb begin
        n_q.zero = i_d.zero;
        if (i_d.y[RV_W-1]) begin
            n_q.x = i_d.x - (i_d.y >>> i_stage);
            n_q.y = i_d.y + (i_d.x >>> i_stage);
            n_q.z = i_d.z - i_angle;
        end else begin
            n_q.x = i_d.x + (i_d.y >>> i_stage);
            n_q.y = i_d.y - (i_d.x >>> i_stage);
            n_q.z = i_d.z + i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

// ===== sv/gcb_sqrt_cell.sv =====
`timescale 1ns / 1ps
module gcb_sqrt_cell (
    input  logic                      i_clk,
    input  logic [gcb_pkg::SQ_W-1:0]  i_bit,
    input  gcb_pkg::t_sq              i_d,
    output gcb_pkg::t_sq              o_q
);
    import gcb_pkg::*;

    t_sq             r_q;
    t_sq             n_q;
    logic [SQ_W-1:0] w_trial;

    // one result bit per cell
    always_comb begin
        w_trial = i_d.r + i_bit;
        if (i_d.v >= w_trial) begin
            n_q.v = i_d.v - w_trial;
            n_q.r = (i_d.r >> 1) + i_bit;
        end else begin
            n_q.v = i_d.v;
            n_q.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

// ===== sv/gcb_checker.sv =====
`timescale 1ns / 1ps
module gcb_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [8:0] o_bearing_deg
);
    import gcb_pkg::*;

    // a result only follows a request taken exactly one latency earlier
    a_done_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without matching request");

    // a request is taken, the matching result shows one latency later
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("request lost");

    // bearing stays within a full turn
    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_bearing_deg < 9'd360))
        else $error("bearing out of range");

    // reset flushes results in flight
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result after reset");
endmodule

bind great_circle_bearing_distance_unit gcb_port_checker u_gcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_bearing_deg (o_bearing_deg)
);

// ===== bench/gcb_checker.sv =====
`timescale 1ns / 1ps
module gcb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [30:0]            i_current_latitude,
    input  logic signed [31:0]            i_current_longitude,
    input  logic                          i_cfg_we,
    input  logic [gcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gcb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          o_done,
    input  logic [8:0]                    o_bearing_deg,
    input  logic [25:0]                   o_distance_m,
    output int                            o_fail_count,
    output int                            o_pending
);
    import gcb_pkg::*;

    localparam longint K_PI      = 64'sd3373259426;
    localparam longint K_HALF_PI = 64'sd1686629713;
    localparam longint K_TWO_PI  = 64'sd6746518852;
    localparam longint K_GAIN    = 64'sd652032874;
    localparam longint K_ONE     = 64'sd1 << 30;

    typedef struct packed {
        logic [8:0]  bearing;
        logic [25:0] meters;
    } t_fix;

    longint      atan_lut [32];
    logic [30:0] tgt_lat;
    logic [31:0] tgt_lon;
    logic [23:0] radius;
    t_fix        fix_q [$];

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    task automatic rotate(input longint ang, output longint s, output longint c);
        longint x, y, z, nx;
        bit     neg;
        x = K_GAIN; y = 0; z = ang; neg = 0;
        while (z > K_PI) z -= K_TWO_PI;
        while (z < -K_PI) z += K_TWO_PI;
        if (z > K_HALF_PI) begin
            z -= K_PI; neg = 1;
        end else if (z < -K_HALF_PI) begin
            z += K_PI; neg = 1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - sra(y, i); y = y + sra(x, i); z -= atan_lut[i];
            end else begin
                nx = x + sra(y, i); y = y - sra(x, i); z += atan_lut[i];
            end
            x = nx;
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic longint vector_angle(longint y, longint x);
        longint z, nx;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? K_PI : -K_PI; x = -x; y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            if (y < 0) begin
                nx = x - sra(y, i); y = y + sra(x, i); z -= atan_lut[i];
            end else begin
                nx = x + sra(y, i); y = y - sra(x, i); z += atan_lut[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_fix(input logic signed [30:0] cl, input logic signed [31:0] cn);
        longint clat, clon, tlat, tlon;
        longint sc, cc, st, ct, sd, cd, h1, k1, h2, k2, y, x, b, a, ang;
        longint unsigned ra, rb, span;
        t_fix f;
        clat = cl; clon = cn;
        tlat = $signed(tgt_lat); tlon = $signed(tgt_lon);
        rotate(2 * clat, sc, cc);
        rotate(2 * tlat, st, ct);
        rotate(2 * (tlon - clon), sd, cd);
        y = fmul(sd, ct);
        x = fmul(cc, st) - fmul(fmul(sc, ct), cd);
        b = vector_angle(y, x);
        f.bearing = 9'((((b + K_TWO_PI) * 180) / K_PI) % 360);
        rotate(tlat - clat, h1, k1);
        rotate(tlon - clon, h2, k2);
        a = fmul(h1, h1) + fmul(fmul(fmul(h2, h2), cc), ct);
        if (a < 0) a = 0;
        if (a > K_ONE) a = K_ONE;
        ra = int_sqrt(longint'(a) << 30);
        rb = int_sqrt(longint'(K_ONE - a) << 30);
        ang = vector_angle(ra, rb);
        if (ang < 0) ang = 0;
        span = (longint'(radius) * ang) >> 29;
        f.meters = 26'(span);
        fix_q.push_back(f);
    endtask

    initial begin
        longint s, t;
        int     sh;
        atan_lut[0] = 64'sd843314857;
        for (int i = 1; i < 32; i++) begin
            s = 0;
            for (int k = 0; k < 32; k++) begin
                sh = i * (2 * k + 1);
                if (sh > 62) break;
                t = longint'((64'd1 << (62 - sh)) / (2 * k + 1));
                s = (k & 1) ? s - t : s + t;
            end
            atan_lut[i] = (s + (64'sd1 << 31)) >>> 32;
        end
    end

    assign o_pending = fix_q.size();

    always @(posedge i_clk) begin
        t_fix e;
        if (!i_rst_n) begin
            tgt_lat      <= '0;
            tgt_lon      <= '0;
            radius       <= RADIUS_RESET;
            o_fail_count <= 0;
            fix_q.delete();
        end else begin
            if (o_done) begin
                if (fix_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result bearing=%0d dist=%0d",
                                 o_bearing_deg, o_distance_m);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = fix_q.pop_front();
                    if (e.bearing !== o_bearing_deg || e.meters !== o_distance_m) begin
                        if (o_fail_count < 10)
                            $display("result: exp bearing=%0d dist=%0d, got %0d %0d",
                                     e.bearing, e.meters, o_bearing_deg, o_distance_m);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                predict_fix(i_current_latitude, i_current_longitude);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TLAT:   tgt_lat <= i_cfg_data[30:0];
                    CFG_TLON:   tgt_lon <= i_cfg_data[31:0];
                    CFG_RADIUS: radius  <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== bench/great_circle_bearing_distance_unit_test.sv =====
`timescale 1ns / 1ps
module great_circle_bearing_distance_unit_test;
    import gcb_pkg::*;

    localparam int LAT_MAX = 843314857;
    localparam int LON_MAX = 1686629713;
    localparam int STALL_LIMIT = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [30:0]   i_current_latitude;
    logic signed [31:0]   i_current_longitude;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_done;
    logic [8:0]           o_bearing_deg;
    logic [25:0]          o_distance_m;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles;

    great_circle_bearing_distance_unit u_top (.*);

    gcb_checker u_check (
        .i_clk, .i_rst_n, .start, .busy, .i_current_latitude, .i_current_longitude,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_done, .o_bearing_deg, .o_distance_m,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: count cycles with neither a request nor a result accepted
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("great_circle_bearing_distance_unit: mismatch");
                $finish;
            end
        end
    end

    function automatic logic signed [30:0] rand_lat();
        case ($urandom_range(0, 9))
            0:       return 31'($urandom);
            1:       return $urandom_range(0, 1) ? 31'(LAT_MAX) : -31'(LAT_MAX);
            default: return 31'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_lon();
        case ($urandom_range(0, 9))
            0:       return 32'($urandom);
            1:       return $urandom_range(0, 1) ? 32'(LON_MAX) : -32'(LON_MAX);
            default: return 32'(longint'($urandom_range(0, 32'hffff_ffff)) % (2 * LON_MAX + 1)
                                - LON_MAX);
        endcase
    endfunction

    // issue one request, with an optional random gap ahead of it
    task automatic send_request(input logic signed [30:0] lat, input logic signed [31:0] lon,
                                input bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        start               <= 1'b1;
        i_current_latitude  <= lat;
        i_current_longitude <= lon;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // drain: hold off until every result is in, then allow the pipe to empty
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic signed [30:0] tl;
        logic signed [31:0] tn;
        i_rst_n = 0; start = 0; i_cfg_we = 0; i_cfg_idx = CFG_TLAT; i_cfg_data = '0;
        i_current_latitude = '0; i_current_longitude = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset waypoint, coincident point, poles, antimeridian, raw extremes
        send_request('0, '0, 0);
        send_request(31'(LAT_MAX), '0, 0);
        send_request(-31'(LAT_MAX), '0, 0);
        send_request('0, 32'(LON_MAX), 0);
        send_request('0, -32'(LON_MAX), 0);
        send_request(31'(LAT_MAX), 32'(LON_MAX), 0);
        send_request(31'h3fff_ffff, 32'h7fff_ffff, 0);
        send_request(31'h4000_0000, 32'h8000_0000, 0);
        send_request(31'h7fff_ffff, 32'hffff_ffff, 0);
        drain();
        write_reg(CFG_TLAT, 32'(31'(LAT_MAX)));
        write_reg(CFG_TLON, 32'(-32'(LON_MAX)));
        write_reg(CFG_RADIUS, 32'hff_ffff);
        send_request(31'(LAT_MAX), -32'(LON_MAX), 0);
        send_request(-31'(LAT_MAX), 32'(LON_MAX), 0);
        send_request('0, '0, 0);
        drain();
        write_reg(CFG_RADIUS, 32'd0);
        send_request('0, '0, 0);
        send_request(-31'(LAT_MAX), '0, 0);
        drain();
        write_reg(CFG_RADIUS, 32'd1);
        write_reg(t_cfg_idx'(3), 32'hffff_ffff);
        send_request('0, 32'd12345, 0);
        drain();

        // random phases, each with a new waypoint and radius
        for (int ph = 0; ph < 12; ph++) begin
            tl = (ph % 4 == 0) ? 31'(LAT_MAX) : rand_lat();
            tn = (ph % 4 == 1) ? -32'(LON_MAX) : rand_lon();
            write_reg(CFG_TLAT, 32'(tl));
            write_reg(CFG_TLON, 32'(tn));
            case (ph % 3)
                0:       write_reg(CFG_RADIUS, 32'(RADIUS_RESET));
                1:       write_reg(CFG_RADIUS, 32'($urandom_range(1, 24'hff_ffff)));
                default: write_reg(CFG_RADIUS, 32'hff_ffff);
            endcase
            for (int n = 0; n < 150; n++) begin
                // nearby points now and then, to work the small-angle path
                if ($urandom_range(0, 3) == 0)
                    send_request(31'(tl + $signed($urandom_range(0, 2000)) - 1000),
                                 32'(tn + $signed($urandom_range(0, 2000)) - 1000), ph < 10);
                else
                    send_request(rand_lat(), rand_lon(), ph < 10);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("great_circle_bearing_distance_unit: match");
        end else begin
            $display("great_circle_bearing_distance_unit: mismatch");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/gcb_pkg.sv
sv/gcb_rot_cell.sv
sv/gcb_vec_cell.sv
sv/gcb_sqrt_cell.sv
sv/great_circle_bearing_distance_unit.sv
sv/gcb_checker.sv
bench/gcb_checker.sv
bench/great_circle_bearing_distance_unit_test.sv
